>>> rtl/core/csq_pkg.sv
// Shared types and constants for the counting semaphore unit.
package csq_pkg;

	localparam int NUM_SEMS   = 16;
	localparam int WAIT_DEPTH = 16;
	localparam int NUM_PIDS   = 32;

	localparam int MODE_W   = 2;
	localparam int SEMID_W  = 4;
	localparam int PID_W    = 5;
	localparam int COUNT_W  = 8;
	localparam int OUTC_W   = 3;

	localparam int SEM_W    = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
	localparam int ID_W     = $clog2(NUM_SEMS + 1);
	localparam int WAIT_W   = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
	localparam int LEN_W    = $clog2(WAIT_DEPTH + 1);
	localparam int ADDR_W   = $clog2(NUM_SEMS * WAIT_DEPTH);

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	localparam int Q_DEPTH  = 2;
	localparam int Q_PTR_W  = $clog2(Q_DEPTH);
	localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

	localparam logic [MODE_W-1:0] MODE_CREATE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LOCK   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_UNLOCK = 2'd2;

	typedef enum logic [1:0] {
		OP_CREATE,
		OP_LOCK,
		OP_UNLOCK,
		OP_BAD
	} op_t;

	typedef enum logic [OUTC_W-1:0] {
		OUTC_CREATED     = 3'd0,
		OUTC_GRANTED     = 3'd1,
		OUTC_SUSPENDED   = 3'd2,
		OUTC_INCREMENTED = 3'd3,
		OUTC_RELEASED    = 3'd4,
		OUTC_ERROR       = 3'd5
	} outc_t;

	typedef enum logic {
		BK_EXEC,
		BK_RELEASE
	} bk_state_t;

	typedef struct packed {
		op_t                op;
		logic [SEM_W-1:0]   sem;
		logic [PID_W-1:0]   pid;
		logic [COUNT_W-1:0] init;
		logic               pid_bad;
	} req_t;

	typedef struct packed {
		logic valid;
		req_t item;
	} req_word_t;

endpackage

>>> rtl/core/counting_semaphore_wait_queues.sv
// Top level of the counting semaphore unit with FIFO wait queues.
// Requests pass the request queue, then the result register; a release also passes the
// registered waiter-storage read. 1 request per cycle, held by out_stall and by releases.
// Front decoder and executor are parted by a 2-word request queue.
// Reset: arst_n clears counts, queue pointers, lengths and the id allocator at once.
// Waiter storage is not cleared; entries are only read after being written.
module counting_semaphore_wait_queues import csq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [MODE_W-1:0]  mode,
	input  logic [SEMID_W-1:0] sem_id,
	input  logic [PID_W-1:0]   caller_pid,
	input  logic [COUNT_W-1:0] initial_count,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [OUTC_W-1:0]  outcome,
	output logic [SEMID_W-1:0] new_sem_id,
	output logic [PID_W-1:0]   released_pid,
	output logic [COUNT_W-1:0] count_after
);

	req_word_t push;
	req_word_t q_head;
	logic      q_full;
	logic      q_pop;

	csq_front u_front (
		.valid         (in_valid),
		.stall         (in_stall),
		.mode          (mode),
		.sem_id        (sem_id),
		.caller_pid    (caller_pid),
		.initial_count (initial_count),
		.q_full        (q_full),
		.push          (push)
	);

	csq_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.head   (q_head),
		.pop    (q_pop)
	);

	csq_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (q_head),
		.pop          (q_pop),
		.valid        (out_valid),
		.stall        (out_stall),
		.outcome      (outcome),
		.new_sem_id   (new_sem_id),
		.released_pid (released_pid),
		.count_after  (count_after)
	);

endmodule

>>> rtl/core/csq_front.sv
// Request decoder: classifies incoming words and pushes them into the queue.
module csq_front import csq_pkg::*; (
	input  logic               valid,
	output logic               stall,
	input  logic [MODE_W-1:0]  mode,
	input  logic [SEMID_W-1:0] sem_id,
	input  logic [PID_W-1:0]   caller_pid,
	input  logic [COUNT_W-1:0] initial_count,
	input  logic               q_full,
	output req_word_t          push
);

	logic sem_bad;

	assign sem_bad = (32'(sem_id) >= NUM_SEMS);
	assign stall   = q_full;

	always_comb begin
		push.valid        = valid;
		push.item.sem     = SEM_W'(sem_id);
		push.item.pid     = caller_pid;
		push.item.init    = initial_count;
		push.item.pid_bad = (32'(caller_pid) >= NUM_PIDS);
		unique case (mode)
			MODE_CREATE: push.item.op = OP_CREATE;
			MODE_LOCK:   push.item.op = sem_bad ? OP_BAD : OP_LOCK;
			MODE_UNLOCK: push.item.op = sem_bad ? OP_BAD : OP_UNLOCK;
			default:     push.item.op = OP_BAD;
		endcase
	end

endmodule

>>> rtl/core/csq_queue.sv
// Two-entry request queue between decoder and executor.
module csq_queue import csq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  req_word_t push,
	output logic      full,
	output req_word_t head,
	input  logic      pop
);

	req_t               mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] cnt_q;
	logic               do_push;
	logic               do_pop;

	assign full       = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign do_push    = push.valid && !full;
	assign head.valid = (cnt_q != '0);
	assign head.item  = mem_q[rd_ptr_q];
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> rtl/core/csq_back.sv
// Executor: semaphore counts, wait-queue pointers, waiter storage and result register.
module csq_back import csq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  req_word_t          head,
	output logic               pop,
	output logic               valid,
	input  logic               stall,
	output logic [OUTC_W-1:0]  outcome,
	output logic [SEMID_W-1:0] new_sem_id,
	output logic [PID_W-1:0]   released_pid,
	output logic [COUNT_W-1:0] count_after
);

	logic [COUNT_W-1:0] count_q [NUM_SEMS];
	logic [WAIT_W-1:0]  head_q  [NUM_SEMS];
	logic [LEN_W-1:0]   len_q   [NUM_SEMS];
	logic [ID_W-1:0]    next_id_q;
	logic [PID_W-1:0]   wait_mem [NUM_SEMS * WAIT_DEPTH];
	logic [PID_W-1:0]   wait_rd_q;
	logic [COUNT_W-1:0] rel_count_q;

	bk_state_t state_q, state_d;

	logic               out_valid_q;
	outc_t              outc_q;
	logic [SEMID_W-1:0] id_q;
	logic [PID_W-1:0]   rpid_q;
	logic [COUNT_W-1:0] cnt_out_q;

	req_t               it;
	logic [COUNT_W-1:0] cnt;
	logic [WAIT_W-1:0]  hd;
	logic [LEN_W-1:0]   len;
	logic [WAIT_W:0]    tail_sum;
	logic [WAIT_W:0]    head_sum;
	logic [WAIT_W-1:0]  tail_slot;
	logic [WAIT_W-1:0]  head_nxt;
	logic [ADDR_W-1:0]  base;

	logic               slot_free;
	logic               is_release;
	logic               res_load;

	outc_t              r_outc;
	logic [SEMID_W-1:0] r_id;
	logic [COUNT_W-1:0] r_cnt;

	logic               upd_en;
	logic [SEM_W-1:0]   upd_idx;
	logic [COUNT_W-1:0] upd_cnt;
	logic [WAIT_W-1:0]  upd_head;
	logic [LEN_W-1:0]   upd_len;
	logic               id_inc;
	logic               mem_we;
	logic               mem_re;
	logic [ADDR_W-1:0]  wr_addr;
	logic [ADDR_W-1:0]  rd_addr;

	assign it        = head.item;
	assign cnt       = count_q[it.sem];
	assign hd        = head_q[it.sem];
	assign len       = len_q[it.sem];
	assign slot_free = !out_valid_q || !stall;

	assign tail_sum  = (WAIT_W + 1)'(hd) + (WAIT_W + 1)'(len);
	assign tail_slot = (tail_sum >= (WAIT_W + 1)'(WAIT_DEPTH)) ?
		WAIT_W'(tail_sum - (WAIT_W + 1)'(WAIT_DEPTH)) : WAIT_W'(tail_sum);
	assign head_sum  = (WAIT_W + 1)'(hd) + 1'b1;
	assign head_nxt  = (head_sum >= (WAIT_W + 1)'(WAIT_DEPTH)) ? '0 : WAIT_W'(head_sum);
	assign base      = ADDR_W'(ADDR_W'(it.sem) * ADDR_W'(WAIT_DEPTH));
	assign wr_addr   = base + ADDR_W'(tail_slot);
	assign rd_addr   = base + ADDR_W'(hd);

	// decode of the head request against current semaphore state
	always_comb begin
		r_outc     = OUTC_ERROR;
		r_id       = '0;
		r_cnt      = '0;
		upd_en     = 1'b0;
		upd_idx    = it.sem;
		upd_cnt    = cnt;
		upd_head   = hd;
		upd_len    = len;
		id_inc     = 1'b0;
		mem_we     = 1'b0;
		is_release = 1'b0;
		unique case (it.op)
			OP_CREATE: begin
				if (next_id_q != ID_W'(NUM_SEMS)) begin
					r_outc   = OUTC_CREATED;
					r_id     = SEMID_W'(next_id_q);
					r_cnt    = it.init;
					upd_en   = 1'b1;
					upd_idx  = SEM_W'(next_id_q);
					upd_cnt  = it.init;
					upd_head = '0;
					upd_len  = '0;
					id_inc   = 1'b1;
				end
			end
			OP_LOCK: begin
				if (it.pid_bad) begin
					r_cnt = cnt;
				end else if (cnt != '0) begin
					r_outc  = OUTC_GRANTED;
					r_cnt   = cnt - 1'b1;
					upd_en  = 1'b1;
					upd_cnt = cnt - 1'b1;
				end else if (len != LEN_W'(WAIT_DEPTH)) begin
					r_outc  = OUTC_SUSPENDED;
					upd_en  = 1'b1;
					upd_len = len + 1'b1;
					mem_we  = 1'b1;
				end
			end
			OP_UNLOCK: begin
				if (len != '0) begin
					is_release = 1'b1;
					r_outc     = OUTC_RELEASED;
					r_cnt      = cnt;
					upd_en     = 1'b1;
					upd_head   = head_nxt;
					upd_len    = len - 1'b1;
				end else begin
					r_outc  = OUTC_INCREMENTED;
					r_cnt   = (cnt == COUNT_MAX) ? cnt : cnt + 1'b1;
					upd_en  = 1'b1;
					upd_cnt = r_cnt;
				end
			end
			default: begin
				r_outc = OUTC_ERROR;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_EXEC: begin
				if (head.valid && slot_free && is_release) begin
					state_d = BK_RELEASE;
				end
			end
			BK_RELEASE: begin
				if (slot_free) begin
					state_d = BK_EXEC;
				end
			end
			default: state_d = BK_EXEC;
		endcase
	end

	always_comb begin
		pop      = 1'b0;
		res_load = 1'b0;
		mem_re   = 1'b0;
		unique case (state_q)
			BK_EXEC: begin
				pop      = head.valid && slot_free;
				res_load = pop && !is_release;
				mem_re   = pop && is_release;
			end
			BK_RELEASE: begin
				res_load = slot_free;
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop && mem_we) begin
			wait_mem[wr_addr] <= it.pid;
		end
		if (mem_re) begin
			wait_rd_q   <= wait_mem[rd_addr];
			rel_count_q <= r_cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SEMS; i++) begin
				count_q[i] <= '0;
				head_q[i]  <= '0;
				len_q[i]   <= '0;
			end
			next_id_q   <= '0;
			state_q     <= BK_EXEC;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop && upd_en) begin
				count_q[upd_idx] <= upd_cnt;
				head_q[upd_idx]  <= upd_head;
				len_q[upd_idx]   <= upd_len;
			end
			if (pop && id_inc) begin
				next_id_q <= next_id_q + 1'b1;
			end
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (!stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			if (state_q == BK_RELEASE) begin
				outc_q    <= OUTC_RELEASED;
				id_q      <= '0;
				rpid_q    <= wait_rd_q;
				cnt_out_q <= rel_count_q;
			end else begin
				outc_q    <= r_outc;
				id_q      <= r_id;
				rpid_q    <= '0;
				cnt_out_q <= r_cnt;
			end
		end
	end

	assign valid        = out_valid_q;
	assign outcome      = outc_q;
	assign new_sem_id   = id_q;
	assign released_pid = rpid_q;
	assign count_after  = cnt_out_q;

endmodule

>>> bench/tb.sv
// Testbench for the counting semaphore unit with FIFO wait queues.
`timescale 1ns / 1ps

module tb import csq_pkg::*;;

	localparam logic [MODE_W-1:0] MODE_ILLEGAL = 2'd3;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_WORDS = 270;

	typedef struct {
		logic [MODE_W-1:0]  mode;
		logic [SEMID_W-1:0] sem;
		logic [PID_W-1:0]   pid;
		logic [COUNT_W-1:0] init;
	} sem_req_t;

	typedef struct {
		outc_t              outc;
		logic [SEMID_W-1:0] id;
		logic [PID_W-1:0]   pid;
		logic [COUNT_W-1:0] count;
	} sem_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [MODE_W-1:0] mode = '0;
	logic [SEMID_W-1:0] sem_id = '0;
	logic [PID_W-1:0] caller_pid = '0;
	logic [COUNT_W-1:0] initial_count = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [OUTC_W-1:0] outcome;
	logic [SEMID_W-1:0] new_sem_id;
	logic [PID_W-1:0] released_pid;
	logic [COUNT_W-1:0] count_after;

	counting_semaphore_wait_queues dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.sem_id(sem_id),
		.caller_pid(caller_pid),
		.initial_count(initial_count),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.outcome(outcome),
		.new_sem_id(new_sem_id),
		.released_pid(released_pid),
		.count_after(count_after)
	);

	always #5 clk = ~clk;

	// shadow semaphore state
	logic [COUNT_W-1:0] sem_cnt [NUM_SEMS];
	logic [PID_W-1:0]   wq_pid [NUM_SEMS][WAIT_DEPTH];
	int                 wq_head [NUM_SEMS];
	int                 wq_len [NUM_SEMS];
	int                 alloc_next;

	sem_req_t req_backlog [$];
	sem_res_t pending_results [$];
	sem_req_t next_req;
	sem_res_t oldest_res;

	int send_idle_pct = 0;
	int stall_pct = 0;
	logic hold_arm = 1'b0;
	logic hold_done = 1'b0;
	int hold_left = 0;
	int mism = 0;
	int cycles = 0;

	function automatic sem_res_t semop_result(sem_req_t r);
		sem_res_t res;
		int s;
		res = '{OUTC_ERROR, '0, '0, '0};
		s = r.sem;
		case (r.mode)
		MODE_CREATE: begin
			if (alloc_next < NUM_SEMS) begin
				sem_cnt[alloc_next] = r.init;
				wq_head[alloc_next] = 0;
				wq_len[alloc_next] = 0;
				res.outc = OUTC_CREATED;
				res.id = alloc_next[SEMID_W-1:0];
				res.count = r.init;
				alloc_next++;
			end
		end
		MODE_LOCK: begin
			if (s < NUM_SEMS) begin
				if (r.pid >= NUM_PIDS) begin
					res.count = sem_cnt[s];
				end else if (sem_cnt[s] != 0) begin
					sem_cnt[s] = sem_cnt[s] - 1'b1;
					res.outc = OUTC_GRANTED;
					res.count = sem_cnt[s];
				end else if (wq_len[s] < WAIT_DEPTH) begin
					wq_pid[s][(wq_head[s] + wq_len[s]) % WAIT_DEPTH] = r.pid;
					wq_len[s]++;
					res.outc = OUTC_SUSPENDED;
				end
			end
		end
		MODE_UNLOCK: begin
			if (s < NUM_SEMS) begin
				if (wq_len[s] > 0) begin
					res.outc = OUTC_RELEASED;
					res.pid = wq_pid[s][wq_head[s]];
					res.count = sem_cnt[s];
					wq_head[s] = (wq_head[s] + 1) % WAIT_DEPTH;
					wq_len[s]--;
				end else begin
					if (sem_cnt[s] != COUNT_MAX)
						sem_cnt[s] = sem_cnt[s] + 1'b1;
					res.outc = OUTC_INCREMENTED;
					res.count = sem_cnt[s];
				end
			end
		end
		default: ;
		endcase
		return res;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			mode <= '0;
			sem_id <= '0;
			caller_pid <= '0;
			initial_count <= '0;
		end else begin
			if (in_valid && !in_stall)
				pending_results.push_back(
					semop_result('{mode, sem_id, caller_pid, initial_count}));
			if (!in_valid || !in_stall) begin
				if (req_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					next_req = req_backlog.pop_front();
					mode <= next_req.mode;
					sem_id <= next_req.sem;
					caller_pid <= next_req.pid;
					initial_count <= next_req.init;
					in_valid <= 1'b1;
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// receiver back-pressure, with one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_arm && !hold_done) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
			out_stall <= 1'b1;
		end else begin
			if (hold_left != 0)
				hold_left <= hold_left - 1;
			out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < stall_pct);
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				mism++;
				if (mism <= 10)
					$display("unexpected word: outcome %0d id %0d pid %0d count %0d",
						outcome, new_sem_id, released_pid, count_after);
			end else begin
				oldest_res = pending_results.pop_front();
				if (outcome !== oldest_res.outc || new_sem_id !== oldest_res.id ||
						released_pid !== oldest_res.pid || count_after !== oldest_res.count) begin
					mism++;
					if (mism <= 10)
						$display({"mismatch: exp outcome %0d id %0d pid %0d count %0d,",
							" got %0d %0d %0d %0d"},
							oldest_res.outc, oldest_res.id, oldest_res.pid, oldest_res.count,
							outcome, new_sem_id, released_pid, count_after);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic queue_req(logic [MODE_W-1:0] m, int s, int p, int c);
		req_backlog.push_back('{m, s[SEMID_W-1:0], p[PID_W-1:0], c[COUNT_W-1:0]});
	endtask

	task automatic settle();
		while (req_backlog.size() != 0 || in_valid || pending_results.size() != 0)
			@(negedge clk);
	endtask

	initial begin : stim
		int made, pick, burst, tgt, sel, init;
		logic [MODE_W-1:0] op;

		for (int i = 0; i < NUM_SEMS; i++) begin
			sem_cnt[i] = '0;
			wq_head[i] = 0;
			wq_len[i] = 0;
		end
		alloc_next = 0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// never-created ids work on reset state
		queue_req(MODE_UNLOCK, 5, 0, 0);
		queue_req(MODE_LOCK, 6, 31, 0);
		queue_req(MODE_UNLOCK, 6, 0, 0);
		// saturation at the top of the count
		queue_req(MODE_CREATE, 15, 31, 255);
		queue_req(MODE_UNLOCK, 0, 0, 0);
		queue_req(MODE_LOCK, 0, 0, 0);
		// waiters released in arrival order
		queue_req(MODE_CREATE, 0, 0, 0);
		queue_req(MODE_LOCK, 1, 0, 0);
		queue_req(MODE_LOCK, 1, 31, 255);
		queue_req(MODE_LOCK, 1, 21, 0);
		queue_req(MODE_UNLOCK, 1, 0, 0);
		queue_req(MODE_UNLOCK, 1, 0, 0);
		queue_req(MODE_UNLOCK, 1, 0, 0);
		queue_req(MODE_UNLOCK, 1, 0, 0);
		queue_req(MODE_LOCK, 1, 10, 0);
		queue_req(MODE_ILLEGAL, 15, 31, 255);
		queue_req(MODE_LOCK, 15, 31, 0);
		queue_req(MODE_UNLOCK, 15, 0, 0);
		queue_req(MODE_CREATE, 7, 3, 1);
		queue_req(MODE_LOCK, 2, 4, 0);
		queue_req(MODE_LOCK, 2, 5, 0);
		settle();

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1) ? 50 : (ph == 3) ? 31 : 0;
			stall_pct = (ph == 2) ? 50 : (ph == 3) ? 31 : 0;
			if (ph == 0)
				hold_arm = 1'b1;
			made = 0;
			while (made < PHASE_WORDS) begin
				pick = $urandom_range(0, 99);
				burst = $urandom_range(1, 24);
				tgt = ($urandom_range(0, 99) < 60) ? $urandom_range(0, 3) : $urandom_range(0, 15);
				if (pick < 6) begin
					sel = $urandom_range(0, 3);
					init = (sel == 0) ? 0 : (sel == 1) ? 255 :
						(sel == 2) ? $urandom_range(0, 3) : $urandom_range(0, 255);
					queue_req(MODE_CREATE, $urandom_range(0, 15), $urandom_range(0, 31), init);
					made++;
				end else if (pick < 11) begin
					queue_req(MODE_W'($urandom_range(0, 3)), $urandom_range(0, 15),
						$urandom_range(0, 31), $urandom_range(0, 255));
					made++;
				end else begin
					op = (pick < 58) ? MODE_LOCK : MODE_UNLOCK;
					repeat (burst) begin
						if ($urandom_range(0, 99) < 12)
							queue_req(MODE_W'($urandom_range(1, 2)), $urandom_range(0, 15),
								$urandom_range(0, 31), $urandom_range(0, 255));
						else
							queue_req(op, tgt, $urandom_range(0, 31), $urandom_range(0, 255));
						made++;
					end
				end
			end
			settle();
		end

		repeat (20) @(posedge clk);
		if (mism == 0 && pending_results.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
